// File: rtl/pmsfr_pkg.sv
// Shared constants and controller/datapath interface types of the sensor frame receiver.
package pmsfr_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int DATA_WORDS_DEFAULT = 12;

    localparam logic [7:0]        START_RESET = 8'h42;
    localparam logic [ADDR_W-1:0] LEN_HI_POS  = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] LEN_LO_POS  = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] CSUM_HI_POS = ADDR_W'(30);
    localparam logic [ADDR_W-1:0] CSUM_LO_POS = ADDR_W'(31);
    localparam logic [ADDR_W-1:0] LAST_POS    = ADDR_W'(FRAME_BYTES - 1);
    localparam logic [ADDR_W-1:0] WORD_BASE   = ADDR_W'(4);
    localparam logic [15:0]       LEN_MAX     = 16'd30;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              byte_take;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              cap_hi;
        logic              sum_clr;
        logic              sum_acc;
        logic              load_ok;
        logic              load_fail;
        logic [3:0]        word_idx;
        logic              word_last;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic              frame_done;
        logic              len_bad;
        logic [ADDR_W-1:0] sum_last;
        logic              sum_match;
        logic              out_busy;
    } dp_status_t;

endpackage

// File: rtl/pmsfr_dp.sv
// Datapath of the sensor frame receiver: frame memory, header capture, checksum and output register.
module pmsfr_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [7:0]            start_byte,
    input  logic [7:0]            rx_byte,
    input  logic                  out_ready,
    input  pmsfr_pkg::dp_cmd_t    cmd,
    output pmsfr_pkg::dp_status_t status,
    output logic                  out_valid,
    output logic                  frame_ok,
    output logic [3:0]            word_index,
    output logic [15:0]           word_value,
    output logic                  last
);
    import pmsfr_pkg::*;

    logic [7:0]        mem [FRAME_BYTES];
    logic [7:0]        start_reg, start_next;
    logic [ADDR_W-1:0] count_reg, count_next;
    logic              open_reg, open_next;
    logic [15:0]       len_reg;
    logic [15:0]       csum_reg;
    logic [15:0]       sum_reg, sum_next;
    logic [7:0]        rd_data_reg;
    logic [7:0]        hi_reg;
    logic              out_valid_reg, out_valid_next;
    logic              ok_reg;
    logic [3:0]        idx_reg;
    logic [15:0]       value_reg;
    logic              last_reg;

    logic              is_start;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    // Byte classification and write address
    assign is_start = (rx_byte == start_reg);
    assign wr_en    = cmd.byte_take && (is_start || open_reg);
    assign wr_addr  = is_start ? '0 : count_reg;

    // Frame tracking: a start byte always reopens, the last byte closes
    always_comb
    begin
        count_next = count_reg;
        open_next  = open_reg;
        if (cmd.byte_take)
        begin
            if (is_start)
            begin
                open_next  = 1'b1;
                count_next = ADDR_W'(1);
            end
            else if (open_reg)
            begin
                count_next = count_reg + ADDR_W'(1);
                if (count_reg == LAST_POS)
                begin
                    open_next = 1'b0;
                end
            end
            else
            begin
                count_next = '0;
            end
        end
    end

    assign start_next = cfg_valid ? start_byte : start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_RESET;
            count_reg <= '0;
            open_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            count_reg <= count_next;
            open_reg  <= open_next;
        end
    end

    // Frame memory with a registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= rx_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    // Length and checksum fields are captured as they are written
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_addr == LEN_HI_POS)
        begin
            len_reg[15:8] <= rx_byte;
        end
        if (wr_en && wr_addr == LEN_LO_POS)
        begin
            len_reg[7:0] <= rx_byte;
        end
        if (wr_en && wr_addr == CSUM_HI_POS)
        begin
            csum_reg[15:8] <= rx_byte;
        end
        if (wr_en && wr_addr == CSUM_LO_POS)
        begin
            csum_reg[7:0] <= rx_byte;
        end
    end

    // Wrapping checksum accumulator
    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.sum_clr)
        begin
            sum_next = '0;
        end
        else if (cmd.sum_acc)
        begin
            sum_next = sum_reg + {8'd0, rd_data_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (cmd.cap_hi)
        begin
            hi_reg <= rd_data_reg;
        end
    end

    // Output register: a result waits here while the next one is prepared
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_ok || cmd.load_fail)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_ok)
        begin
            ok_reg    <= 1'b1;
            idx_reg   <= cmd.word_idx;
            value_reg <= {hi_reg, rd_data_reg};
            last_reg  <= cmd.word_last;
        end
        else if (cmd.load_fail)
        begin
            ok_reg    <= 1'b0;
            idx_reg   <= '0;
            value_reg <= '0;
            last_reg  <= 1'b1;
        end
    end

    // Status back to the controller
    assign status.frame_done = !is_start && open_reg && (count_reg == LAST_POS);
    assign status.len_bad    = (len_reg > LEN_MAX);
    assign status.sum_last   = len_reg[ADDR_W-1:0] + ADDR_W'(1);
    assign status.sum_match  = (sum_reg == csum_reg);
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign frame_ok   = ok_reg;
    assign word_index = idx_reg;
    assign word_value = value_reg;
    assign last       = last_reg;

endmodule

// File: rtl/pmsfr_ctrl.sv
// Controller of the sensor frame receiver: sequences reception, checksum and word output.
module pmsfr_ctrl #(
    parameter int DATA_WORDS = pmsfr_pkg::DATA_WORDS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pmsfr_pkg::dp_status_t status,
    output pmsfr_pkg::dp_cmd_t    cmd
);
    import pmsfr_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DATA_WORDS - 1);

    typedef enum logic [8:0] {
        ST_RECV  = 9'b000000001,
        ST_CHECK = 9'b000000010,
        ST_S_RD  = 9'b000000100,
        ST_S_ACC = 9'b000001000,
        ST_CMP   = 9'b000010000,
        ST_W_RDH = 9'b000100000,
        ST_W_RDL = 9'b001000000,
        ST_W_OUT = 9'b010000000,
        ST_F_OUT = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              accept;
    logic [ADDR_W-1:0] word_addr;

    assign in_ready  = (state_reg == ST_RECV);
    assign accept    = in_valid && in_ready;
    assign word_addr = WORD_BASE + {idx_reg[ADDR_W-2:0], 1'b0};

    // Next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.word_idx  = idx_reg[3:0];
        cmd.word_last = (idx_reg == LAST_IDX);
        case (state_reg)
            ST_RECV:
            begin
                cmd.byte_take = accept;
                if (accept && status.frame_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.sum_clr = 1'b1;
                idx_next    = '0;
                state_next  = status.len_bad ? ST_F_OUT : ST_S_RD;
            end
            ST_S_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = idx_reg;
                state_next  = ST_S_ACC;
            end
            ST_S_ACC:
            begin
                cmd.sum_acc = 1'b1;
                if (idx_reg == status.sum_last)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = ST_S_RD;
                end
            end
            ST_CMP:
            begin
                idx_next   = '0;
                state_next = status.sum_match ? ST_W_RDH : ST_F_OUT;
            end
            ST_W_RDH:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = word_addr;
                state_next  = ST_W_RDL;
            end
            ST_W_RDL:
            begin
                cmd.cap_hi  = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = word_addr + ADDR_W'(1);
                state_next  = ST_W_OUT;
            end
            ST_W_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_ok = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_RECV;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = ST_W_RDH;
                    end
                end
            end
            ST_F_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_fail = 1'b1;
                    state_next    = ST_RECV;
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// File: rtl/pm_sensor_frame_receiver.sv
// Bytes are taken one per cycle while in_ready is high and a frame fills; the 32nd byte
// starts the frame check, which reads frame bytes 0 to length+1 one at a time into the
// checksum; then each data word takes two reads of the single read port and one load.
// A failed frame yields its result after the length check (bad length) or the checksum compare.
// Bytes are not taken while a frame is checked or output; a transfer out may stall it.
// Reset (rst_n, asynchronous, active low) closes any frame and sets the start byte to 0x42.
module pm_sensor_frame_receiver #(
    parameter int DATA_WORDS = pmsfr_pkg::DATA_WORDS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  start_byte,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_ok,
    output logic [3:0]  word_index,
    output logic [15:0] word_value,
    output logic        last
);
    import pmsfr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The start byte register takes every transfer
    assign cfg_ready = 1'b1;

    pmsfr_ctrl #(
        .DATA_WORDS(DATA_WORDS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pmsfr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .start_byte (start_byte),
        .rx_byte    (rx_byte),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .frame_ok   (frame_ok),
        .word_index (word_index),
        .word_value (word_value),
        .last       (last)
    );

endmodule
